[rtl/msc_pkg.sv]
package msc_pkg;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GAIN       = 2'd0;
	localparam cfg_idx_t CFG_RANGE      = 2'd1;
	localparam cfg_idx_t CFG_ZERO_LIMIT = 2'd2;

	localparam logic [15:0] GAIN_RESET       = 16'd16384;
	localparam logic [30:0] RANGE_RESET      = 31'd448462848;
	localparam logic [15:0] ZERO_LIMIT_RESET = 16'd5000;

	localparam int          ELAPSED_W   = 17;
	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

	// what the scaler tells the health tracker about one sample
	typedef struct packed {
		logic is_zero;
		logic over_range;
	} scale_flags_t;

	function automatic logic [31:0] magnitude(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

endpackage

[rtl/msc_scale.sv]
module msc_scale (
	input  logic [15:0]         gain,
	input  logic [30:0]         range_limit,
	input  logic [7:0]          x_low,
	input  logic [7:0]          x_high,
	input  logic [7:0]          y_low,
	input  logic [7:0]          y_high,
	input  logic [7:0]          z_low,
	input  logic [7:0]          z_high,
	output logic signed [31:0]  north,
	output logic signed [31:0]  east,
	output logic signed [31:0]  down,
	output msc_pkg::scale_flags_t flags
);
	import msc_pkg::*;

	logic signed [32:0] ax, ay, az;
	logic signed [32:0] gs;
	logic signed [32:0] px, py, pz;
	logic signed [31:0] sx;

	// sign-extend each little-endian axis
	assign ax = $signed({{17{x_high[7]}}, x_high, x_low});
	assign ay = $signed({{17{y_high[7]}}, y_high, y_low});
	assign az = $signed({{17{z_high[7]}}, z_high, z_low});
	assign gs = $signed({17'd0, gain});

	assign px = ax * gs;
	assign py = ay * gs;
	assign pz = az * gs;

	// |product| < 2^31, so 32 bits hold it exactly
	assign sx    = px[31:0];
	assign north = py[31:0];
	assign east  = 32'(-sx);
	assign down  = pz[31:0];

	assign flags.is_zero    = (px == '0) && (py == '0) && (pz == '0);
	assign flags.over_range = (magnitude(north) > {1'b0, range_limit})
		|| (magnitude(east) > {1'b0, range_limit})
		|| (magnitude(down) > {1'b0, range_limit});

endmodule

[rtl/msc_tracker.sv]
module msc_tracker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  kind,
	input  msc_pkg::scale_flags_t flags,
	input  logic [15:0]           zero_limit_ms,
	output logic                  warn,
	output logic [31:0]           sample_number
);
	import msc_pkg::*;

	logic [ELAPSED_W-1:0] zero_elapsed_q;
	logic                 seen_q;
	logic [31:0]          sample_count_q;
	logic                 stale;

	// zero vector after the first sample keeps the timer running
	assign stale = flags.is_zero && seen_q;

	assign warn = (stale && (zero_elapsed_q > {1'b0, zero_limit_ms})) || flags.over_range;
	assign sample_number = sample_count_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_elapsed_q <= '0;
			seen_q         <= 1'b0;
			sample_count_q <= '0;
		end else if (step) begin
			if (!kind) begin
				if (seen_q && (zero_elapsed_q != ELAPSED_MAX))
					zero_elapsed_q <= zero_elapsed_q + 1'b1;
			end else begin
				sample_count_q <= sample_number;
				if (!stale) begin
					zero_elapsed_q <= '0;
					seen_q         <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/magnetometer_sample_conditioner.sv]
// Magnetometer sample conditioner. Each input word is a millisecond tick
// (kind 0, no result) or a raw sample (kind 1, one result word). A word passes
// an input register and then scaling, NED rotation and health checks into the
// result register, so the block takes one word per clock; the three 16x16 gain
// multipliers between the two registers set the clock limit. A stalled result
// lets the input register fill and then holds the input; words keep flowing
// while the result side is ready.
// Outputs are in 2^-14 converter LSB. Configuration writes are always ready,
// index 3 is ignored, and are meant to happen only while the block is idle.
module magnetometer_sample_conditioner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  msc_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic                kind,
	input  logic [7:0]          x_low,
	input  logic [7:0]          x_high,
	input  logic [7:0]          y_low,
	input  logic [7:0]          y_high,
	input  logic [7:0]          z_low,
	input  logic [7:0]          z_high,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  north,
	output logic signed [31:0]  east,
	output logic signed [31:0]  down,
	output logic                health,
	output logic [31:0]         sample_number
);
	import msc_pkg::*;

	logic [15:0] gain_q;
	logic [30:0] range_limit_q;
	logic [15:0] zero_limit_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  x_low_s1, x_high_s1, y_low_s1, y_high_s1, z_low_s1, z_high_s1;

	logic               valid_s2;
	logic signed [31:0] north_s2, east_s2, down_s2;
	logic               health_s2;
	logic [31:0]        number_s2;

	logic               advance;
	logic               load_s1;
	logic               step;
	logic signed [31:0] north_c, east_c, down_c;
	scale_flags_t       flags_c;
	logic               warn_c;
	logic [31:0]        number_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RESET;
			range_limit_q <= RANGE_RESET;
			zero_limit_q  <= ZERO_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN:       gain_q        <= cfg_data[15:0];
				CFG_RANGE:      range_limit_q <= cfg_data[30:0];
				CFG_ZERO_LIMIT: zero_limit_q  <= cfg_data[15:0];
				default:        ;
			endcase
		end
	end

	// stage 1 moves on unless a finished result is still held
	// an empty stage 1 still takes a word
	assign advance      = !valid_s2 || !result_stall;
	assign load_s1      = !valid_s1 || advance;
	assign step         = valid_s1 && advance;
	assign sample_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid) begin
			kind_s1   <= kind;
			x_low_s1  <= x_low;
			x_high_s1 <= x_high;
			y_low_s1  <= y_low;
			y_high_s1 <= y_high;
			z_low_s1  <= z_low;
			z_high_s1 <= z_high;
		end
	end

	msc_scale u_scale (
		.gain        (gain_q),
		.range_limit (range_limit_q),
		.x_low       (x_low_s1),
		.x_high      (x_high_s1),
		.y_low       (y_low_s1),
		.y_high      (y_high_s1),
		.z_low       (z_low_s1),
		.z_high      (z_high_s1),
		.north       (north_c),
		.east        (east_c),
		.down        (down_c),
		.flags       (flags_c)
	);

	msc_tracker u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.kind          (kind_s1),
		.flags         (flags_c),
		.zero_limit_ms (zero_limit_q),
		.warn          (warn_c),
		.sample_number (number_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && kind_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && kind_s1) begin
			north_s2  <= north_c;
			east_s2   <= east_c;
			down_s2   <= down_c;
			health_s2 <= warn_c;
			number_s2 <= number_c;
		end
	end

	assign result_valid  = valid_s2;
	assign north         = north_s2;
	assign east          = east_s2;
	assign down          = down_s2;
	assign health        = health_s2;
	assign sample_number = number_s2;

endmodule

[rtl/msc_checker.sv]
module msc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] north,
	input logic        health,
	input logic [31:0] sample_number
);

	// a held result word keeps its valid and payload
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(sample_number) && $stable(north)
			&& $stable(health))
		else $error("result word changed while stalled");

	// each result word counts one sample past the one before it
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall ##1 result_valid
			|-> sample_number == $past(sample_number) + 32'd1)
		else $error("sample number skipped or repeated");

	// input is only held back by a waiting result word
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled with no result pending");

endmodule

bind magnetometer_sample_conditioner msc_checker u_msc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_stall  (sample_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.north         (north),
	.health        (health),
	.sample_number (sample_number)
);
